### rtl/mfmc_pkg.sv
// Package: payload types and fixed constants of the max-flow / min-cut engine.
package mfmc_pkg;

    localparam int CAP_W  = 24;
    localparam int FLOW_W = 28;
    localparam int SIDE_W = 16;
    localparam int NID_W  = 4;

    localparam logic [CAP_W-1:0]  CAP_MAX  = {CAP_W{1'b1}};
    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_SINK   = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [NID_W-1:0] from_node;
        logic [NID_W-1:0] to_node;
        logic [CAP_W-1:0] cap_value;
    } t_in_item;

    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic [SIDE_W-1:0] source_side;
    } t_out_item;

endpackage

### rtl/max_flow_min_cut_engine_unit.sv
// Edmonds-Karp max-flow engine: residual matrix memory, search sequencer and result register.
// A capacity write is taken while idle; a clear zeroes the matrix one entry a cycle. A run, for
// every search, dequeues nodes, reads each one's bottleneck and scans its row of NODES entries,
// then reads the parent and both residuals per path edge pushed and writes both residuals back.
// Throughput: one item at a time; stall stays high until the current item is finished.
// Reset: synchronous, active low; a clearing pass zeroes the matrix
// before the first item is taken. Configuration writes are taken at any time.
module max_flow_min_cut_engine_unit #(
    parameter int NODES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mfmc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mfmc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [3:0]           i_cfg_data
);
    import mfmc_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] NODES_A  = AW'(NODES);
    localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
    localparam logic [NW:0]   NODES_C  = (NW+1)'(NODES);
    localparam logic [NW-1:0] LAST_N   = NW'(NODES - 1);

    typedef enum logic [13:0] {
        S_CLR    = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_BINIT  = 14'b00000000000100,
        S_POP    = 14'b00000000001000,
        S_POP2   = 14'b00000000010000,
        S_POP3   = 14'b00000000100000,
        S_SCAN   = 14'b00000001000000,
        S_PUSH   = 14'b00000010000000,
        S_PUSH_P = 14'b00000100000000,
        S_PUSH_B = 14'b00001000000000,
        S_PUSH_F = 14'b00010000000000,
        S_PUSH_W = 14'b00100000000000,
        S_RINIT  = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] row,
                                                 input logic [NW-1:0] col);
        cell_addr = AW'(row) * NODES_A + AW'(col);
    endfunction

    // Memories
    logic [CAP_W-1:0] m_res [DEPTH];
    logic [NW-1:0]    m_q   [NODES];
    logic [CAP_W-1:0] m_lim [NODES];
    logic [NW-1:0]    m_par [NODES];

    logic [CAP_W-1:0] r_res_rd, r_lim_rd;
    logic [NW-1:0]    r_q_rd, r_par_rd;

    logic             res_we, q_we, lim_we, par_we;
    logic [AW-1:0]    res_wa, res_ra;
    logic [CAP_W-1:0] res_wd, lim_wd;
    logic [NW-1:0]    q_wa, q_wd, q_ra, lim_wa, lim_ra, par_wa, par_wd, par_ra;

    // Control and datapath registers
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [NW:0]      r_head, n_head, r_tail, n_tail, r_guard, n_guard;
    logic [NW-1:0]    r_cur, n_cur, r_nx, n_nx, r_p, n_p;
    logic [CAP_W-1:0] r_cur_lim, n_cur_lim, r_amt, n_amt, r_back, n_back;
    logic [FLOW_W-1:0] r_flow, n_flow;
    logic [SIDE_W-1:0] r_side, n_side;
    logic [NODES-1:0] r_seen, n_seen;
    logic             r_reach, n_reach;
    logic [3:0]       r_src, r_snk;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic [NW-1:0]    src_n, snk_n;
    logic             hit;
    logic [CAP_W-1:0] scan_lim;
    logic [CAP_W:0]   back_sum;
    logic [FLOW_W:0]  flow_sum;

    assign src_n       = NW'(r_src);
    assign snk_n       = NW'(r_snk);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign hit      = !r_seen[r_nx] && (r_res_rd != '0);
    assign scan_lim = (r_cur_lim < r_res_rd) ? r_cur_lim : r_res_rd;
    assign back_sum = {1'b0, r_back} + {1'b0, r_amt};
    assign flow_sum = {1'b0, r_flow} + (FLOW_W+1)'(r_amt);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_guard     = r_guard;
        n_cur       = r_cur;
        n_nx        = r_nx;
        n_p         = r_p;
        n_cur_lim   = r_cur_lim;
        n_amt       = r_amt;
        n_back      = r_back;
        n_flow      = r_flow;
        n_side      = r_side;
        n_seen      = r_seen;
        n_reach     = r_reach;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = '0;
        q_we   = 1'b0; q_wa   = '0; q_wd   = '0; q_ra   = '0;
        lim_we = 1'b0; lim_wa = '0; lim_wd = '0; lim_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;

        unique case (r_state)
            // Sweep zeros through the matrix
            S_CLR: begin
                res_we = 1'b1;
                res_wa = r_clr_addr;
                if (r_clr_addr == LAST_A) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            // Take one transaction
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_in_item.kind == KIND_WRITE) begin
                        if (32'(i_in_item.from_node) < NODES
                                && 32'(i_in_item.to_node) < NODES) begin
                            res_we = 1'b1;
                            res_wa = cell_addr(NW'(i_in_item.from_node),
                                               NW'(i_in_item.to_node));
                            res_wd = i_in_item.cap_value;
                        end
                    end else if (i_in_item.kind == KIND_CLEAR) begin
                        n_clr_addr = '0;
                        n_state    = S_CLR;
                    end else if (i_in_item.kind == KIND_RUN) begin
                        n_flow = '0;
                        n_side = '0;
                        priority if (32'(r_src) >= NODES || 32'(r_snk) >= NODES) begin
                            n_state = S_OUT;
                        end else if (r_src == r_snk) begin
                            n_state = S_RINIT;
                        end else begin
                            n_state = S_BINIT;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            // Seed the path search at the source
            S_BINIT: begin
                n_seen  = '0;
                n_seen[src_n] = 1'b1;
                q_we    = 1'b1;
                q_wa    = '0;
                q_wd    = src_n;
                lim_we  = 1'b1;
                lim_wa  = src_n;
                lim_wd  = CAP_MAX;
                n_head  = '0;
                n_tail  = (NW+1)'(1);
                n_reach = 1'b0;
                n_state = S_POP;
            end
            // Seed the reachability sweep at the source
            S_RINIT: begin
                n_seen  = '0;
                n_seen[src_n] = 1'b1;
                q_we    = 1'b1;
                q_wa    = '0;
                q_wd    = src_n;
                n_head  = '0;
                n_tail  = (NW+1)'(1);
                n_reach = 1'b1;
                n_side  = '0;
                n_state = S_POP;
            end
            // Dequeue the next node, or finish the search
            S_POP: begin
                if (r_head == r_tail) begin
                    n_state = r_reach ? S_OUT : S_RINIT;
                end else begin
                    q_ra    = r_head[NW-1:0];
                    n_head  = r_head + 1'b1;
                    n_state = S_POP2;
                end
            end
            S_POP2: begin
                n_cur  = r_q_rd;
                lim_ra = r_q_rd;
                if (r_reach) begin
                    n_side = r_side | (SIDE_W'(1) << r_q_rd);
                end
                n_state = S_POP3;
            end
            // Start the row scan of the current node
            S_POP3: begin
                n_cur_lim = r_lim_rd;
                n_nx      = '0;
                res_ra    = cell_addr(r_cur, '0);
                n_state   = S_SCAN;
            end
            // Check one neighbor per cycle, prefetch the next
            S_SCAN: begin
                if (hit && !r_reach && r_nx == snk_n) begin
                    n_seen[r_nx] = 1'b1;
                    par_we  = 1'b1;
                    par_wa  = r_nx;
                    par_wd  = r_cur;
                    n_amt   = scan_lim;
                    n_cur   = snk_n;
                    n_guard = '0;
                    n_state = S_PUSH;
                end else begin
                    if (hit) begin
                        n_seen[r_nx] = 1'b1;
                        if (!r_reach) begin
                            par_we = 1'b1;
                            par_wa = r_nx;
                            par_wd = r_cur;
                            lim_we = 1'b1;
                            lim_wa = r_nx;
                            lim_wd = scan_lim;
                        end
                        if (r_tail < NODES_C) begin
                            q_we   = 1'b1;
                            q_wa   = r_tail[NW-1:0];
                            q_wd   = r_nx;
                            n_tail = r_tail + 1'b1;
                        end
                    end
                    if (r_nx == LAST_N) begin
                        n_state = S_POP;
                    end else begin
                        n_nx   = r_nx + 1'b1;
                        res_ra = cell_addr(r_cur, r_nx + 1'b1);
                    end
                end
            end
            // Walk the path back from the sink
            S_PUSH: begin
                if (r_cur == src_n || r_guard == NODES_C) begin
                    n_flow  = (flow_sum > (FLOW_W+1)'(FLOW_MAX)) ? FLOW_MAX
                                                                 : flow_sum[FLOW_W-1:0];
                    n_state = S_BINIT;
                end else begin
                    par_ra  = r_cur;
                    n_state = S_PUSH_P;
                end
            end
            S_PUSH_P: begin
                n_p     = r_par_rd;
                res_ra  = cell_addr(r_cur, r_par_rd);
                n_state = S_PUSH_B;
            end
            S_PUSH_B: begin
                n_back  = r_res_rd;
                res_ra  = cell_addr(r_p, r_cur);
                n_state = S_PUSH_F;
            end
            // Lower the forward residual
            S_PUSH_F: begin
                res_we  = 1'b1;
                res_wa  = cell_addr(r_p, r_cur);
                res_wd  = r_res_rd - r_amt;
                n_state = S_PUSH_W;
            end
            // Raise the reverse residual, saturating
            S_PUSH_W: begin
                res_we  = 1'b1;
                res_wa  = cell_addr(r_cur, r_p);
                res_wd  = back_sum[CAP_W] ? CAP_MAX : back_sum[CAP_W-1:0];
                n_cur   = r_p;
                n_guard = r_guard + 1'b1;
                n_state = S_PUSH;
            end
            // Hand the result to the output register
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.total_flow  = r_flow;
                    n_out.source_side = r_side;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_src       <= 4'd0;
            r_snk       <= 4'd15;
            r_head      <= '0;
            r_tail      <= '0;
            r_guard     <= '0;
            r_reach     <= 1'b0;
            r_seen      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_guard     <= n_guard;
            r_reach     <= n_reach;
            r_seen      <= n_seen;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SOURCE: r_src <= i_cfg_data;
                    CFG_SINK:   r_snk <= i_cfg_data;
                    default:    r_src <= r_src;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_nx      <= n_nx;
        r_p       <= n_p;
        r_cur_lim <= n_cur_lim;
        r_amt     <= n_amt;
        r_back    <= n_back;
        r_flow    <= n_flow;
        r_side    <= n_side;
        r_out     <= n_out;
    end

    // Residual matrix
    always_ff @(posedge i_clk) begin
        if (res_we) begin
            m_res[res_wa] <= res_wd;
        end
        r_res_rd <= m_res[res_ra];
    end

    // Search queue, bottleneck and parent stores
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_q[q_wa] <= q_wd;
        end
        if (lim_we) begin
            m_lim[lim_wa] <= lim_wd;
        end
        if (par_we) begin
            m_par[par_wa] <= par_wd;
        end
        r_q_rd   <= m_q[q_ra];
        r_lim_rd <= m_lim[lim_ra];
        r_par_rd <= m_par[par_ra];
    end

    // Checks
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= NODES_C)
        else $error("queue tail beyond node count");

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_POP2 || r_state == S_POP3) |-> r_head <= r_tail)
        else $error("queue head passed tail");

    a_guard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard <= NODES_C)
        else $error("path walk longer than node count");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result shown without a finished run");

    a_push_not_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH_F || r_state == S_PUSH_W) |-> !r_reach)
        else $error("flow push during reachability sweep");

endmodule
